@@ design/uf2x_pkg.sv @@
`timescale 1ns / 1ps
package uf2x_pkg;

  localparam int unsigned BLOCK_WORDS = 128;
  localparam int unsigned POS_W = $clog2(BLOCK_WORDS);
  localparam int unsigned SIZE_WORD = 4;
  localparam int unsigned DATA_WORD = 8;

  localparam logic [31:0] MAGIC_FIRST = 32'h0A32_4655;
  localparam logic [31:0] MAGIC_SECOND = 32'h9E5D_5157;

  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 476;
  localparam int unsigned LEN_W = 9;

  localparam int unsigned BEAT_BYTES = 8;
  localparam int unsigned BEAT_W = 8 * BEAT_BYTES;
  localparam int unsigned BEAT_CNT_W = 4;

  localparam int unsigned ADDR_W = 24;
  localparam int unsigned CNT_W = 25;
  localparam logic [CNT_W-1:0] REGION_BYTES_RST = CNT_W'(1048576);

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BYTES = 2'd1;

  // Parser to beat sequencer
  typedef struct packed {
    logic             start;
    logic             clear;
    logic [LEN_W-1:0] len;
  } uf2x_req_t;

  // Store write port
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] idx;
    logic [31:0]      data;
  } uf2x_wr_t;

endpackage

@@ design/uf2x_if.sv @@
`timescale 1ns / 1ps
interface uf2x_in_if import uf2x_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] file_word;
  logic        restart;

  modport source (output valid, file_word, restart, input ready);
  modport sink (input valid, file_word, restart, output ready);
endinterface

interface uf2x_out_if import uf2x_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ADDR_W-1:0]     write_address;
  logic [BEAT_W-1:0]     beat_data;
  logic [BEAT_CNT_W-1:0] beat_bytes;
  logic                  last_of_block;
  logic                  region_full;

  modport source (output valid, write_address, beat_data, beat_bytes, last_of_block,
                  region_full, input ready);
  modport sink (input valid, write_address, beat_data, beat_bytes, last_of_block,
                region_full, output ready);
endinterface

interface uf2x_cfg_if import uf2x_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, wr_index, wr_data, input ready);
  modport sink (input valid, wr_index, wr_data, output ready);
endinterface

@@ design/uf2x_store.sv @@
`timescale 1ns / 1ps
module uf2x_store import uf2x_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  localparam int unsigned STORE_DEPTH = (MAX_PAYLOAD_BYTES + 3) / 4,
  localparam int unsigned BANK_DEPTH = (STORE_DEPTH + 1) / 2,
  localparam int unsigned BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  uf2x_wr_t             wr_i,
  input  logic                 rd_en_i,
  input  logic [BANK_AW-1:0]   rd_addr_i,
  output logic [BEAT_W-1:0]    rd_data_o
);
  // Even payload words in bank 0, odd in bank 1: one beat reads both at the same row
  logic [31:0] even_mem [BANK_DEPTH];
  logic [31:0] odd_mem [BANK_DEPTH];
  logic [31:0] even_q, odd_q;
  logic [BANK_AW-1:0] wr_row;

  assign wr_row = BANK_AW'(wr_i.idx >> 1);

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.idx[0]) begin
      even_mem[wr_row] <= wr_i.data;
    end
    if (wr_i.en && wr_i.idx[0]) begin
      odd_mem[wr_row] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      even_q <= even_mem[rd_addr_i];
      odd_q  <= odd_mem[rd_addr_i];
    end
  end

  assign rd_data_o = {odd_q, even_q};
endmodule

@@ design/uf2x_parser.sv @@
`timescale 1ns / 1ps
module uf2x_parser import uf2x_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  uf2x_in_if.sink     file_i,
  input  logic        busy_i,
  output uf2x_req_t   req_o,
  output uf2x_wr_t    wr_o
);
  localparam int unsigned STORE_DEPTH = (MAX_PAYLOAD_BYTES + 3) / 4;

  logic             accept;
  logic [POS_W-1:0] pos_q, pos_d, pos;
  logic             magic_q, magic_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [POS_W-1:0] data_idx;

  assign file_i.ready = !busy_i;
  assign accept = file_i.valid && !busy_i;

  // A restart word is word 0 of a fresh block
  assign pos = file_i.restart ? '0 : pos_q;
  assign data_idx = pos - POS_W'(DATA_WORD);

  always_comb begin
    pos_d   = pos_q;
    magic_d = magic_q;
    len_d   = len_q;
    if (accept) begin
      pos_d = pos + 1'b1;
      if (pos == '0) begin
        magic_d = (file_i.file_word == MAGIC_FIRST);
      end else if (pos == POS_W'(1)) begin
        magic_d = magic_q && (file_i.file_word == MAGIC_SECOND);
      end else if (pos == POS_W'(SIZE_WORD)) begin
        len_d = (file_i.file_word >= 32'd1 &&
                 file_i.file_word <= 32'(MAX_PAYLOAD_BYTES)) ?
                LEN_W'(file_i.file_word) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      magic_q <= 1'b0;
      len_q   <= '0;
    end else begin
      pos_q   <= pos_d;
      magic_q <= magic_d;
      len_q   <= len_d;
    end
  end

  assign wr_o.en   = accept && (pos >= POS_W'(DATA_WORD)) &&
                     (data_idx < POS_W'(STORE_DEPTH));
  assign wr_o.idx  = data_idx;
  assign wr_o.data = file_i.file_word;

  assign req_o.clear = accept && file_i.restart;
  assign req_o.start = accept && (pos == POS_W'(BLOCK_WORDS - 1)) && magic_q &&
                       (len_q != '0);
  assign req_o.len   = len_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.start |-> !req_o.clear)
    else $error("block end coincides with restart");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |=> (pos_q > POS_W'(DATA_WORD)))
    else $error("payload write outside data words");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_o.start |=> (pos_q == '0))
    else $error("position did not wrap after block end");
endmodule

@@ design/uf2x_drain.sv @@
`timescale 1ns / 1ps
module uf2x_drain import uf2x_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  localparam int unsigned STORE_DEPTH = (MAX_PAYLOAD_BYTES + 3) / 4,
  localparam int unsigned BANK_DEPTH = (STORE_DEPTH + 1) / 2,
  localparam int unsigned BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  uf2x_req_t            req_i,
  input  logic [ADDR_W-1:0]    region_base_i,
  input  logic [CNT_W-1:0]     region_bytes_i,
  output logic                 busy_o,
  output logic                 rd_en_o,
  output logic [BANK_AW-1:0]   rd_addr_o,
  input  logic [BEAT_W-1:0]    rd_data_i,
  uf2x_out_if.source           beat_o
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [LEN_W-1:0]      rem_q, rem_d;
  logic [BANK_AW-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]      bw_q, bw_d;
  logic                  stop_q, stop_d;
  logic                  ovld_q, ovld_d;
  logic [ADDR_W-1:0]     addr_q;
  logic [BEAT_W-1:0]     data_q;
  logic [BEAT_CNT_W-1:0] bytes_q;
  logic                  last_q, full_q;

  logic [CNT_W-1:0]      room, len_ext, n;
  logic [BEAT_CNT_W-1:0] take;
  logic [CNT_W-1:0]      bw_next;
  logic                  last_beat, full_beat, load;
  logic [BEAT_W-1:0]     data_m;

  assign room    = region_bytes_i - bw_q;
  assign len_ext = CNT_W'(req_i.len);
  assign n       = (len_ext < room) ? len_ext : room;

  assign last_beat = (rem_q <= LEN_W'(BEAT_BYTES));
  assign take      = last_beat ? BEAT_CNT_W'(rem_q) : BEAT_CNT_W'(BEAT_BYTES);
  assign bw_next   = bw_q + CNT_W'(take);
  assign full_beat = (bw_next >= region_bytes_i);
  assign load      = (state_q == ST_LOAD) && (!ovld_q || beat_o.ready);

  always_comb begin
    for (int k = 0; k < BEAT_BYTES; k++) begin
      data_m[8*k +: 8] = (BEAT_CNT_W'(k) < take) ? rd_data_i[8*k +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    idx_d   = idx_q;
    bw_d    = bw_q;
    stop_d  = stop_q;
    ovld_d  = ovld_q && !beat_o.ready;
    if (req_i.clear) begin
      bw_d   = '0;
      stop_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (req_i.start && !stop_q && (bw_q < region_bytes_i)) begin
          rem_d   = LEN_W'(n);
          idx_d   = '0;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (load) begin
          ovld_d = 1'b1;
          bw_d   = bw_next;
          rem_d  = rem_q - LEN_W'(take);
          idx_d  = idx_q + 1'b1;
          if (full_beat) begin
            stop_d = 1'b1;
          end
          state_d = last_beat ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
      idx_q   <= '0;
      bw_q    <= '0;
      stop_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
      bw_q    <= bw_d;
      stop_q  <= stop_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      addr_q  <= region_base_i + bw_q[ADDR_W-1:0];
      data_q  <= data_m;
      bytes_q <= take;
      last_q  <= last_beat;
      full_q  <= full_beat;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign rd_en_o   = (state_q == ST_READ);
  assign rd_addr_o = idx_q;

  assign beat_o.valid         = ovld_q;
  assign beat_o.write_address = addr_q;
  assign beat_o.beat_data     = data_q;
  assign beat_o.beat_bytes    = bytes_q;
  assign beat_o.last_of_block = last_q;
  assign beat_o.region_full   = full_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == ST_IDLE))
    else $error("block end request while draining");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovld_q |-> (bytes_q != '0) && (bytes_q <= BEAT_CNT_W'(BEAT_BYTES)))
    else $error("beat byte count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && full_q) |-> last_q)
    else $error("region full on a beat that is not last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && full_beat && !req_i.clear) |=> stop_q)
    else $error("region filled but writing not stopped");
endmodule

@@ design/uf2_payload_extractor.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Handshake         Payload
// file_i    in   valid / ready     file_word[31:0], restart
// beat_o    out  valid / ready     write_address[23:0], beat_data[63:0], beat_bytes[3:0],
//                                  last_of_block, region_full
// cfg_i     in   valid / ready     wr_index[1:0], wr_data[24:0]
//
// File words are taken one per cycle, while the sequencer is idle, into the banked payload store.
// After the last word of a valid block, input stalls while the sequencer drains
// beats: each beat is a store read, then an output load, up to 60 beats.
// The final beat sits in the output register while the next block streams in.
// rst_ni clears the control state and loads the register defaults; the store
// needs no clearing pass. A stalled beat_o holds the sequencer in its load step.
module uf2_payload_extractor import uf2x_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  uf2x_in_if.sink       file_i,
  uf2x_out_if.source    beat_o,
  uf2x_cfg_if.sink      cfg_i
);
  localparam int unsigned STORE_DEPTH = (MAX_PAYLOAD_BYTES + 3) / 4;
  localparam int unsigned BANK_DEPTH = (STORE_DEPTH + 1) / 2;
  localparam int unsigned BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [ADDR_W-1:0]  region_base_q;
  logic [CNT_W-1:0]   region_bytes_q;
  uf2x_req_t          req;
  uf2x_wr_t           wr;
  logic               busy;
  logic               rd_en;
  logic [BANK_AW-1:0] rd_addr;
  logic [BEAT_W-1:0]  rd_data;

  // Configuration requests are always taken; writes to unknown indexes drop.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_base_q  <= '0;
      region_bytes_q <= REGION_BYTES_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.wr_index)
        REG_REGION_BASE:  region_base_q  <= cfg_i.wr_data[ADDR_W-1:0];
        REG_REGION_BYTES: region_bytes_q <= cfg_i.wr_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Count words, check magic and size, fill the store
  uf2x_parser #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .file_i (file_i),
    .busy_i (busy),
    .req_o  (req),
    .wr_o   (wr)
  );

  // Payload words, even and odd banks
  uf2x_store #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Cut the payload to the room left and emit beats
  uf2x_drain #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)) u_drain (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .region_base_i  (region_base_q),
    .region_bytes_i (region_bytes_q),
    .busy_o         (busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .beat_o         (beat_o)
  );
endmodule

@@ bench/tb_uf2_payload_extractor.sv @@
`timescale 1ns / 1ps
module tb_uf2_payload_extractor;
  import uf2x_pkg::*;

  // Run length guard: generous multiple of the slowest legal run
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Quiet cycles after the last beat before touching registers or ending
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned STORE_WORDS = (MAX_PAYLOAD_BYTES_DEF + 3) / 4;
  localparam logic [31:0] END_MAGIC = 32'h0AB1_6F30;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    BLK_GOOD,
    BLK_BAD_FIRST,
    BLK_BAD_SECOND
  } blk_kind_e;

  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic [BEAT_W-1:0]     data;
    logic [BEAT_CNT_W-1:0] nbytes;
    logic                  last;
    logic                  full;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  uf2x_in_if  file_if ();
  uf2x_out_if beat_if ();
  uf2x_cfg_if cfg_if ();

  uf2_payload_extractor dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .file_i (file_if),
    .beat_o (beat_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser, the payload buffer, the
  // region bookkeeping and both registers.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]  blk_pos;
  bit                hdr_ok;
  logic [LEN_W-1:0]  plen_chk;
  logic [31:0]       pay_mem [STORE_WORDS];
  logic [CNT_W-1:0]  wr_total;
  bit                halted;
  logic [ADDR_W-1:0] base_reg;
  logic [CNT_W-1:0]  size_reg;

  beat_t       pending_beats [$];
  logic [31:0] blk_q [$];

  int unsigned words_sent = 0;
  int unsigned beats_seen = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  function automatic void reset_model();
    blk_pos  = '0;
    hdr_ok   = 1'b0;
    plen_chk = '0;
    for (int i = 0; i < STORE_WORDS; i++) pay_mem[i] = '0;
    wr_total = '0;
    halted   = 1'b0;
    base_reg = '0;
    size_reg = REGION_BYTES_RST;
  endfunction

  // Absorb one file word; at the last word of a good block push every beat
  // that the payload yields, cut to the room left in the region.
  function automatic void absorb_file_word(logic [31:0] w, logic rs);
    int unsigned room, n, done, take, idx;
    beat_t b;
    if (rs) begin
      blk_pos  = '0;
      hdr_ok   = 1'b0;
      wr_total = '0;
      halted   = 1'b0;
    end
    if (blk_pos == 0) begin
      hdr_ok = (w == MAGIC_FIRST);
    end else if (blk_pos == 1) begin
      hdr_ok = hdr_ok && (w == MAGIC_SECOND);
    end else if (blk_pos == SIZE_WORD) begin
      plen_chk = (w >= 1 && w <= MAX_PAYLOAD_BYTES_DEF) ? w[LEN_W-1:0] : '0;
    end else if (blk_pos >= DATA_WORD && blk_pos - DATA_WORD < STORE_WORDS) begin
      pay_mem[blk_pos - DATA_WORD] = w;
    end

    if (blk_pos == BLOCK_WORDS - 1 && hdr_ok && plen_chk != 0 && !halted
        && wr_total < size_reg) begin
      room = size_reg - wr_total;
      n    = (plen_chk < room) ? plen_chk : room;
      done = 0;
      while (done < n) begin
        take = n - done;
        if (take > BEAT_BYTES) take = BEAT_BYTES;
        b.data = '0;
        for (int k = 0; k < take; k++) begin
          idx = done + k;
          b.data[8*k +: 8] = 8'(pay_mem[idx >> 2] >> (8 * (idx % 4)));
        end
        b.addr   = base_reg + wr_total[ADDR_W-1:0];
        b.nbytes = BEAT_CNT_W'(take);
        wr_total = CNT_W'(wr_total + take);
        done     = done + take;
        b.last   = (done == n);
        b.full   = (wr_total >= size_reg);
        if (b.full) halted = 1'b1;
        pending_beats.push_back(b);
      end
    end
    blk_pos = blk_pos + 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Payload sizes lean to the edges: tiny payloads and nearly full ones
  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 35) return $urandom_range(16, 1);
    if (r < 55) return $urandom_range(MAX_PAYLOAD_BYTES_DEF, MAX_PAYLOAD_BYTES_DEF - 7);
    return $urandom_range(MAX_PAYLOAD_BYTES_DEF, 1);
  endfunction

  // Fill blk_q with one 128-word block: header, random target fields, random
  // payload. The end magic is not checked, so randomize it half the time.
  function automatic void make_block(logic [31:0] size_word, blk_kind_e kind);
    blk_q.delete();
    for (int i = 0; i < BLOCK_WORDS; i++) blk_q.push_back($urandom());
    blk_q[0]        = MAGIC_FIRST;
    blk_q[1]        = MAGIC_SECOND;
    blk_q[SIZE_WORD] = size_word;
    if (kind == BLK_BAD_FIRST) blk_q[0] = blk_q[0] ^ (32'h1 << $urandom_range(31, 0));
    if (kind == BLK_BAD_SECOND) blk_q[1] = blk_q[1] ^ (32'h1 << $urandom_range(31, 0));
    if ($urandom_range(1, 0)) blk_q[BLOCK_WORDS-1] = END_MAGIC;
  endfunction

  // Send one file word; caller sits at a rising edge, returns at the edge
  // where the request was taken.
  task automatic send_word(logic [31:0] w, logic rs);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      file_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    file_if.valid     <= 1'b1;
    file_if.file_word <= w;
    file_if.restart   <= rs;
    do @(posedge clk_i); while (!(file_if.valid && file_if.ready));
  endtask

  // Send the first n words of blk_q, flagging restart on word 0 if asked
  task automatic send_blk(int unsigned n, bit rs);
    for (int i = 0; i < n; i++) send_word(blk_q[i], (i == 0) && rs);
  endtask

  // Drop valid, let every predicted beat arrive, then give the sequencer
  // time to finish any block that had nothing to emit.
  task automatic wait_drained();
    file_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write request; returns at the next edge after it was taken
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid    <= 1'b1;
    cfg_if.wr_index <= idx;
    cfg_if.wr_data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_region(logic [ADDR_W-1:0] base, logic [CNT_W-1:0] bytes);
    cfg_write(REG_REGION_BASE, CFG_DATA_W'(base));
    cfg_write(REG_REGION_BYTES, bytes);
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Reset defaults: largest payload (60 beats, short tail) then smallest one
  task automatic test_payload_extremes();
    steady = 1'b0;
    make_block(MAX_PAYLOAD_BYTES_DEF, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    make_block(32'd1, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    wait_drained();
  endtask

  // Broken headers emit nothing; a good block after them must still line up
  task automatic test_bad_headers();
    steady = 1'b1;
    make_block(32'd40, BLK_BAD_FIRST);
    send_blk(BLOCK_WORDS, 1'b0);
    make_block(32'd40, BLK_BAD_SECOND);
    send_blk(BLOCK_WORDS, 1'b0);
    steady = 1'b0;
    make_block(32'd0, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    make_block(MAX_PAYLOAD_BYTES_DEF + 1, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    make_block(32'hFFFF_FFFF, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    make_block(32'd13, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    wait_drained();
  endtask

  // Restart partway through a block: discard the partial block and realign
  task automatic test_restart_mid_block();
    make_block(32'd200, BLK_GOOD);
    send_blk(50, 1'b1);
    make_block(32'd20, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    wait_drained();
  endtask

  // Payload larger than the room left: cut, flag full, ignore until restart
  task automatic test_partial_fit();
    set_region(24'h123456, 25'd37);
    make_block(32'd100, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    make_block(32'd50, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    make_block(32'd9, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    wait_drained();
  endtask

  // Zero-sized region never has room; one-byte region takes one byte
  task automatic test_tiny_regions();
    set_region(24'h000000, 25'd0);
    make_block(MAX_PAYLOAD_BYTES_DEF, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    wait_drained();
    cfg_write(REG_REGION_BYTES, 25'd1);
    make_block(32'd300, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    wait_drained();
  endtask

  // Largest region at the top of the address space: addresses wrap
  task automatic test_large_region();
    steady = 1'b1;
    set_region(24'hFFFFFF, 25'd16777216);
    make_block(32'd30, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b1);
    steady = 1'b0;
    make_block(MAX_PAYLOAD_BYTES_DEF, BLK_GOOD);
    send_blk(BLOCK_WORDS, 1'b0);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Random stream: phases of random region settings, each with a few blocks,
  // mostly well formed, the rest bad headers, bad sizes and cut-off blocks.
  // Ends with an incomplete trailing block.
  // ---------------------------------------------------------------------------
  task automatic test_random_stream();
    int unsigned start_words, nblk, r;
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  bytes;
    bit force_rs, rs;
    start_words = words_sent;
    force_rs = 1'b1;
    while ((words_sent - start_words) < 460) begin
      wait_drained();
      r = $urandom_range(3, 0);
      base = (r == 0) ? 24'h000000 :
             (r == 1) ? ADDR_W'(24'hFFFFFF - $urandom_range(64, 0)) : ADDR_W'($urandom());
      r = $urandom_range(9, 0);
      if (r == 0) bytes = 25'd1;
      else if (r < 3) bytes = CNT_W'($urandom_range(40, 1));
      else if (r < 6) bytes = CNT_W'($urandom_range(2000, 100));
      else if (r < 8) bytes = 25'd16777216;
      else bytes = CNT_W'($urandom_range(16777216, 1));
      set_region(base, bytes);
      steady = ($urandom_range(3, 0) == 0);
      nblk = $urandom_range(3, 1);
      for (int b = 0; b < nblk; b++) begin
        rs = force_rs || (b == 0 && $urandom_range(1, 0)) || ($urandom_range(9, 0) == 0);
        force_rs = 1'b0;
        r = $urandom_range(99, 0);
        if (r < 70) begin
          make_block(pick_size(), BLK_GOOD);
          send_blk(BLOCK_WORDS, rs);
        end else if (r < 78) begin
          make_block(pick_size(), r[0] ? BLK_BAD_FIRST : BLK_BAD_SECOND);
          send_blk(BLOCK_WORDS, rs);
        end else if (r < 88) begin
          r = $urandom_range(2, 0);
          make_block((r == 0) ? 32'd0 :
                     (r == 1) ? $urandom_range(511, MAX_PAYLOAD_BYTES_DEF + 1) :
                                ($urandom() | 32'h200), BLK_GOOD);
          send_blk(BLOCK_WORDS, rs);
        end else begin
          // Cut the block short; realign the next one with a restart
          make_block(pick_size(), BLK_GOOD);
          send_blk($urandom_range(BLOCK_WORDS - 1, 1), rs);
          force_rs = 1'b1;
        end
      end
    end
    make_block(pick_size(), BLK_GOOD);
    send_blk($urandom_range(BLOCK_WORDS - 1, 1), 1'b1);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: hold ready high or low for random stretches,
  // mostly short, a few long; hold it high through steady stretches.
  // ---------------------------------------------------------------------------
  int unsigned rdy_hold = 0;
  logic        rdy_level = 1'b1;

  always @(posedge clk_i) begin
    int unsigned r;
    if (steady) begin
      beat_if.ready <= 1'b1;
      rdy_hold = 0;
    end else begin
      if (rdy_hold == 0) begin
        rdy_level = ($urandom_range(99, 0) < 70);
        r = $urandom_range(99, 0);
        rdy_hold = (r < 75) ? $urandom_range(4, 1) :
                   (r < 95) ? $urandom_range(12, 5) : $urandom_range(40, 20);
      end
      beat_if.ready <= rdy_level;
      rdy_hold--;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: track register writes, predict on every accepted file word and
  // check every accepted beat against the oldest prediction. Predict before
  // checking so both orders within one edge give the same answer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beat_t got, want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.wr_index)
          REG_REGION_BASE: begin
            base_reg = cfg_if.wr_data[ADDR_W-1:0];
          end
          REG_REGION_BYTES: begin
            size_reg = cfg_if.wr_data;
          end
          default: begin
          end
        endcase
      end
      if (file_if.valid && file_if.ready) begin
        absorb_file_word(file_if.file_word, file_if.restart);
        words_sent++;
      end
      if (beat_if.valid && beat_if.ready) begin
        got.addr   = beat_if.write_address;
        got.data   = beat_if.beat_data;
        got.nbytes = beat_if.beat_bytes;
        got.last   = beat_if.last_of_block;
        got.full   = beat_if.region_full;
        beats_seen++;
        if (pending_beats.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected beat addr %06h data %016h bytes %0d last %0b full %0b",
                     $realtime, got.addr, got.data, got.nbytes, got.last, got.full);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: beat mismatch", $realtime);
              $display("  addr %06h / %06h  data %016h / %016h", want.addr, got.addr,
                       want.data, got.data);
              $display("  bytes %0d / %0d  last %0b / %0b  full %0b / %0b (expected / got)",
                       want.nbytes, got.nbytes, want.last, got.last, want.full, got.full);
            end
          end
        end
      end
    end
  end

  // Hard stop if the run hangs
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still pending", cycles,
               pending_beats.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    file_if.valid     = 1'b0;
    file_if.file_word = '0;
    file_if.restart   = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.wr_index   = '0;
    cfg_if.wr_data    = '0;
    beat_if.ready     = 1'b0;
    reset_model();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_payload_extremes();
    test_bad_headers();
    test_restart_mid_block();
    test_partial_fit();
    test_tiny_regions();
    test_large_region();
    test_random_stream();

    $display("covered: %0d file words, %0d beats checked over directed and random phases",
             words_sent, beats_seen);
    $display("mismatches or stray beats: %0d", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
